// ===== design/jexif_pkg.sv =====
// ----------------------------------------------------------------------------
// jexif_pkg
// Types and constants shared by the segment extractor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jexif_pkg;

    localparam logic [7:0] MK_PREFIX     = 8'hFF;
    localparam logic [7:0] MK_SOI        = 8'hD8;
    localparam logic [7:0] MK_EOI        = 8'hD9;
    localparam logic [7:0] MK_SOS        = 8'hDA;
    localparam logic [7:0] TARGET_RESET  = 8'hE1;
    localparam logic [7:0] ORDER_MM      = 8'h4D;
    localparam logic [7:0] ORDER_II      = 8'h49;
    localparam logic [15:0] TIFF_MAGIC   = 16'd42;

    // "Exif\0\0"
    localparam logic [7:0] EXIF_SIG [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

    typedef enum logic [3:0] {
        PH_SOI_FF   = 4'd0,
        PH_SOI_CODE = 4'd1,
        PH_MK_FF    = 4'd2,
        PH_MK_CODE  = 4'd3,
        PH_SKIP_HI  = 4'd4,
        PH_SKIP_LO  = 4'd5,
        PH_SKIP     = 4'd6,
        PH_SEG_HI   = 4'd7,
        PH_SEG_LO   = 4'd8,
        PH_SEG      = 4'd9
    } phase_t;

    typedef enum logic [3:0] {
        ST_SCAN      = 4'd0,
        ST_PAYLOAD   = 4'd1,
        ST_HEADER_OK = 4'd2,
        ST_NOT_JPEG  = 4'd3,
        ST_BAD_PFX   = 4'd4,
        ST_NO_SEG    = 4'd5,
        ST_BAD_EXIF  = 4'd6,
        ST_BAD_TIFF  = 4'd7,
        ST_TRUNC     = 4'd8,
        ST_SHORT_LEN = 4'd9
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        payload_last;
        logic        big_endian;
        logic [31:0] ifd_offset;
    } result_t;

    localparam int TDATA_W = 64;

endpackage

`default_nettype wire

// ===== design/jexif_core.sv =====
// ----------------------------------------------------------------------------
// jexif_core
// Marker scan state and per-byte result logic, one byte per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jexif_core
    import jexif_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_of_file,
    input  wire logic       last_of_file,
    input  wire logic [7:0] target_marker,
    output result_t         result
);

    phase_t      phase_reg,  phase_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pos_reg,    pos_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic        ord_ok_reg, ord_ok_next;
    logic        big_reg,    big_next;
    logic [15:0] magic_reg,  magic_next;
    logic [31:0] offset_reg, offset_next;
    logic        done_reg,   done_next;

    always_comb
    begin
        phase_t      ph;
        logic [15:0] len;
        logic [15:0] rem_dec;
        logic [15:0] rel;

        // a new file clears the parse before its first byte is taken
        if (first_of_file)
        begin
            ph          = PH_SOI_FF;
            len_hi_next = '0;
            remain_next = '0;
            pos_next    = '0;
            hdr_ok_next = 1'b0;
            ord_ok_next = 1'b0;
            big_next    = 1'b0;
            magic_next  = '0;
            offset_next = '0;
            done_next   = 1'b0;
        end
        else
        begin
            ph          = phase_reg;
            len_hi_next = len_hi_reg;
            remain_next = remain_reg;
            pos_next    = pos_reg;
            hdr_ok_next = hdr_ok_reg;
            ord_ok_next = ord_ok_reg;
            big_next    = big_reg;
            magic_next  = magic_reg;
            offset_next = offset_reg;
            done_next   = done_reg;
        end
        phase_next = ph;
        len        = {len_hi_next, data_byte};
        rem_dec    = remain_next - 16'd1;
        rel        = pos_next - 16'd10;
        result     = '0;

        if (!done_next)
        begin
            unique case (ph)
                PH_SOI_FF:
                begin
                    if (data_byte == MK_PREFIX)
                        phase_next = PH_SOI_CODE;
                    else
                    begin
                        result.status = ST_NOT_JPEG;
                        done_next     = 1'b1;
                    end
                end
                PH_SOI_CODE:
                begin
                    if (data_byte == MK_SOI)
                        phase_next = PH_MK_FF;
                    else
                    begin
                        result.status = ST_NOT_JPEG;
                        done_next     = 1'b1;
                    end
                end
                PH_MK_FF:
                begin
                    if (data_byte == MK_PREFIX)
                        phase_next = PH_MK_CODE;
                    else
                    begin
                        result.status = ST_BAD_PFX;
                        done_next     = 1'b1;
                    end
                end
                PH_MK_CODE:
                begin
                    // target compared first so it may equal SOS, SOI or EOI
                    priority if (data_byte == target_marker)
                        phase_next = PH_SEG_HI;
                    else if (data_byte == MK_SOS)
                    begin
                        result.status = ST_NO_SEG;
                        done_next     = 1'b1;
                    end
                    else if (data_byte == MK_SOI || data_byte == MK_EOI)
                        phase_next = PH_MK_FF;
                    else
                        phase_next = PH_SKIP_HI;
                end
                PH_SKIP_HI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_SKIP_LO;
                end
                PH_SEG_HI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_SEG_LO;
                end
                PH_SKIP_LO:
                begin
                    remain_next = len - 16'd2;
                    phase_next  = (len == 16'd2) ? PH_MK_FF : PH_SKIP;
                end
                PH_SKIP:
                begin
                    remain_next = rem_dec;
                    if (rem_dec == 16'd0)
                        phase_next = PH_MK_FF;
                end
                PH_SEG_LO:
                begin
                    priority if (len < 16'd2)
                    begin
                        result.status = ST_SHORT_LEN;
                        done_next     = 1'b1;
                    end
                    else if (len == 16'd2)
                    begin
                        result.status = ST_BAD_EXIF;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        remain_next = len - 16'd2;
                        pos_next    = '0;
                        hdr_ok_next = 1'b1;
                        ord_ok_next = 1'b1;
                        big_next    = 1'b0;
                        magic_next  = '0;
                        offset_next = '0;
                        phase_next  = PH_SEG;
                    end
                end
                PH_SEG:
                begin
                    result.status        = ST_PAYLOAD;
                    result.payload_valid = 1'b1;
                    result.payload_byte  = data_byte;
                    result.payload_index = pos_next;

                    // header, byte order, magic and offset capture
                    if (pos_next < 16'd6)
                    begin
                        if (data_byte != EXIF_SIG[pos_next[2:0]])
                            hdr_ok_next = 1'b0;
                    end
                    else if (pos_next == 16'd6)
                    begin
                        priority if (data_byte == ORDER_MM)
                            big_next = 1'b1;
                        else if (data_byte == ORDER_II)
                            big_next = 1'b0;
                        else
                            ord_ok_next = 1'b0;
                    end
                    else if (pos_next == 16'd7)
                    begin
                        if (data_byte != (big_next ? ORDER_MM : ORDER_II))
                            ord_ok_next = 1'b0;
                    end
                    else if (pos_next < 16'd10)
                    begin
                        if (big_next)
                            magic_next = {magic_next[7:0], data_byte};
                        else if (pos_next[0])
                            magic_next = {data_byte, magic_next[7:0]};
                        else
                            magic_next = {magic_next[15:8], data_byte};
                    end
                    else if (pos_next < 16'd14)
                    begin
                        if (big_next)
                            offset_next = {offset_next[23:0], data_byte};
                        else
                            offset_next = offset_next
                                | ({24'd0, data_byte} << {rel[1:0], 3'b000});
                    end

                    remain_next = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        result.payload_last = 1'b1;
                        done_next           = 1'b1;
                        priority if (pos_next < 16'd5 || !hdr_ok_next)
                            result.status = ST_BAD_EXIF;
                        else if (pos_next < 16'd13 || !ord_ok_next
                                 || magic_next != TIFF_MAGIC)
                            result.status = ST_BAD_TIFF;
                        else
                        begin
                            result.status     = ST_HEADER_OK;
                            result.big_endian = big_next;
                            result.ifd_offset = offset_next;
                        end
                    end
                    else
                        pos_next = pos_next + 16'd1;
                end
                default:
                begin
                    result.status = ST_BAD_PFX;
                    done_next     = 1'b1;
                end
            endcase

            if (last_of_file && !done_next)
            begin
                result.status = ST_TRUNC;
                done_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI_FF;
            len_hi_reg <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b0;
            ord_ok_reg <= 1'b0;
            big_reg    <= 1'b0;
            magic_reg  <= '0;
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            ord_ok_reg <= ord_ok_next;
            big_reg    <= big_next;
            magic_reg  <= magic_next;
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/jpeg_exif_segment_extractor.sv =====
// ----------------------------------------------------------------------------
// jpeg_exif_segment_extractor
// JPEG marker scanner that extracts one marker segment and checks its Exif header.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the s_ channel, one byte per word; s_tuser marks
// the first byte of a file and s_tlast the final one. Every accepted word
// gives exactly one result word on the m_ channel: status and payload_valid
// in m_tuser, payload byte, index, byte order and IFD offset in m_tdata,
// and m_tlast on the final payload byte of the target segment.
// The cfg channel writes the target marker code (APP1 after reset); write it
// only while no word is in flight.
// Path: an accepted byte is held in the input register, then the parse logic
// writes its result word into the result register that drives m_.
// Throughput: one byte per cycle while m_tready stays high; the parse state
// in jexif_core updates once per accepted byte.
// Reset clears the parse state and both pipeline registers and restores the
// target marker. When m_tready is low the pipeline holds; up to two words
// are kept inside, and s_tready falls only once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_exif_segment_extractor
    import jexif_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] data_byte
    input  wire logic               s_tuser,   // [0] first_of_file
    input  wire logic               s_tlast,   // last_of_file
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                               // [24] big_endian, [56:25] ifd_offset
    output logic [4:0]              m_tuser,   // [3:0] status, [4] payload_valid
    output logic                    m_tlast,   // payload_last
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data   // target_marker
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic [7:0] target_reg;
    logic       advance;
    result_t    result;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    jexif_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_valid_reg && advance),
        .data_byte     (in_byte_reg),
        .first_of_file (in_first_reg),
        .last_of_file  (in_last_reg),
        .target_marker (target_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= TARGET_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                target_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_byte_reg  <= '0;
            in_first_reg <= 1'b0;
            in_last_reg  <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            if (s_tready && s_tvalid)
            begin
                in_byte_reg  <= s_tdata;
                in_first_reg <= s_tuser;
                in_last_reg  <= s_tlast;
            end
            if (advance && in_valid_reg)
                out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.payload_last;
    assign m_tuser  = {out_reg.payload_valid, out_reg.status};
    assign m_tdata  = {7'd0, out_reg.ifd_offset, out_reg.big_endian,
                       out_reg.payload_index, out_reg.payload_byte};

    // payload words only carry payload, end-of-segment or truncation verdicts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |->
            (m_tuser[3:0] == ST_PAYLOAD || m_tuser[3:0] == ST_HEADER_OK
             || m_tuser[3:0] == ST_BAD_EXIF || m_tuser[3:0] == ST_BAD_TIFF
             || m_tuser[3:0] == ST_TRUNC))
        else $error("payload word with unexpected status");

    // a header-ok verdict always sits on the last payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:0] == ST_HEADER_OK |-> m_tlast && m_tuser[4])
        else $error("header ok outside last payload byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[4])
        else $error("segment end without payload byte");

    // input only backs up when the result stage is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && in_valid_reg)
        else $error("input stalled without downstream backpressure");

endmodule

`default_nettype wire

// ===== test/tb_jpeg_exif_segment_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jpeg_exif_segment_extractor
// Streams generated JPEG files through the extractor under random sender gaps,
// receiver stalls and several target marker settings. A local parser model
// predicts the result word of every byte and checks each field on m_.
// ----------------------------------------------------------------------------

module tb_jpeg_exif_segment_extractor;
    import jexif_pkg::*;

    localparam int LONG_HOLD    = 100;
    localparam int PHASE_BYTES  = 220;
    localparam int SETTLE_TICKS = 6;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIG,
        FLAW_ORDER,
        FLAW_MAGIC,
        FLAW_SHORT,
        FLAW_TRUNC,
        FLAW_NO_FF,
        FLAW_SOS_FIRST,
        FLAW_TINY_LEN,
        FLAW_WRAP_SKIP,
        FLAW_NOISE,
        FLAW_BAD_SOI
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       eof;
        logic       drain;
    } file_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               s_tuser = 1'b0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [4:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data = 8'h00;

    file_byte_t pending_bytes[$];
    result_t    expected_words[$];
    logic [7:0] file_bytes[$];
    logic [7:0] gen_target = TARGET_RESET;
    int         queued_total = 0;
    int         mismatch_count = 0;
    int         holdoff_requests = 0;
    logic       in_fire = 1'b0;

    // parser model state
    logic [7:0]  target_code = TARGET_RESET;
    phase_t      scan_phase = PH_SOI_FF;
    logic [7:0]  len_hi = 8'h00;
    logic [15:0] remain = 16'h0000;
    logic [15:0] pos = 16'h0000;
    logic        hdr_good = 1'b0;
    logic        order_good = 1'b0;
    logic        tiff_big = 1'b0;
    logic [15:0] magic = 16'h0000;
    logic [31:0] ifd_off = 32'h0;
    logic        verdict_done = 1'b0;

    jpeg_exif_segment_extractor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic clear_parser();
        scan_phase   = PH_SOI_FF;
        len_hi       = 8'h00;
        remain       = 16'h0000;
        pos          = 16'h0000;
        hdr_good     = 1'b0;
        order_good   = 1'b0;
        tiff_big     = 1'b0;
        magic        = 16'h0000;
        ifd_off      = 32'h0;
        verdict_done = 1'b0;
    endtask

    // one byte into the parser model, one result word out
    task automatic parse_byte(input logic [7:0] d, input logic sof, input logic eof,
                              output result_t r);
        logic [15:0] seg_len;
        r = '0;
        r.status = ST_SCAN;
        if (sof)
            clear_parser();
        if (!verdict_done)
        begin
            seg_len = {len_hi, d};
            case (scan_phase)
                PH_SOI_FF:
                    if (d == MK_PREFIX)
                        scan_phase = PH_SOI_CODE;
                    else
                    begin
                        r.status = ST_NOT_JPEG;
                        verdict_done = 1'b1;
                    end
                PH_SOI_CODE:
                    if (d == MK_SOI)
                        scan_phase = PH_MK_FF;
                    else
                    begin
                        r.status = ST_NOT_JPEG;
                        verdict_done = 1'b1;
                    end
                PH_MK_FF:
                    if (d == MK_PREFIX)
                        scan_phase = PH_MK_CODE;
                    else
                    begin
                        r.status = ST_BAD_PFX;
                        verdict_done = 1'b1;
                    end
                PH_MK_CODE:
                    // target wins over the fixed codes
                    if (d == target_code)
                        scan_phase = PH_SEG_HI;
                    else if (d == MK_SOS)
                    begin
                        r.status = ST_NO_SEG;
                        verdict_done = 1'b1;
                    end
                    else if (d == MK_SOI || d == MK_EOI)
                        scan_phase = PH_MK_FF;
                    else
                        scan_phase = PH_SKIP_HI;
                PH_SKIP_HI:
                begin
                    len_hi = d;
                    scan_phase = PH_SKIP_LO;
                end
                PH_SEG_HI:
                begin
                    len_hi = d;
                    scan_phase = PH_SEG_LO;
                end
                PH_SKIP_LO:
                begin
                    remain = seg_len - 16'd2;
                    scan_phase = (remain == 16'd0) ? PH_MK_FF : PH_SKIP;
                end
                PH_SKIP:
                begin
                    remain = remain - 16'd1;
                    if (remain == 16'd0)
                        scan_phase = PH_MK_FF;
                end
                PH_SEG_LO:
                    if (seg_len < 16'd2)
                    begin
                        r.status = ST_SHORT_LEN;
                        verdict_done = 1'b1;
                    end
                    else if (seg_len == 16'd2)
                    begin
                        r.status = ST_BAD_EXIF;
                        verdict_done = 1'b1;
                    end
                    else
                    begin
                        remain     = seg_len - 16'd2;
                        pos        = 16'd0;
                        hdr_good   = 1'b1;
                        order_good = 1'b1;
                        tiff_big   = 1'b0;
                        magic      = 16'h0000;
                        ifd_off    = 32'h0;
                        scan_phase = PH_SEG;
                    end
                PH_SEG:
                begin
                    r.status        = ST_PAYLOAD;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = d;
                    r.payload_index = pos;
                    if (pos < 16'd6)
                    begin
                        if (d != EXIF_SIG[pos[2:0]])
                            hdr_good = 1'b0;
                    end
                    else if (pos == 16'd6)
                    begin
                        if (d == ORDER_MM)
                            tiff_big = 1'b1;
                        else if (d == ORDER_II)
                            tiff_big = 1'b0;
                        else
                            order_good = 1'b0;
                    end
                    else if (pos == 16'd7)
                    begin
                        if (d != (tiff_big ? ORDER_MM : ORDER_II))
                            order_good = 1'b0;
                    end
                    else if (pos < 16'd10)
                        magic = tiff_big ? {magic[7:0], d}
                                         : magic | (16'(d) << (8 * (pos - 16'd8)));
                    else if (pos < 16'd14)
                        ifd_off = tiff_big ? {ifd_off[23:0], d}
                                           : ifd_off | (32'(d) << (8 * (pos - 16'd10)));
                    remain = remain - 16'd1;
                    if (remain == 16'd0)
                    begin
                        r.payload_last = 1'b1;
                        verdict_done = 1'b1;
                        if (pos < 16'd5 || !hdr_good)
                            r.status = ST_BAD_EXIF;
                        else if (pos < 16'd13 || !order_good || magic != TIFF_MAGIC)
                            r.status = ST_BAD_TIFF;
                        else
                        begin
                            r.status     = ST_HEADER_OK;
                            r.big_endian = tiff_big;
                            r.ifd_offset = ifd_off;
                        end
                    end
                    else
                        pos = pos + 16'd1;
                end
                default:
                begin
                    r.status = ST_BAD_PFX;
                    verdict_done = 1'b1;
                end
            endcase
            if (eof && !verdict_done)
            begin
                r.status = ST_TRUNC;
                verdict_done = 1'b1;
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // input acceptance feeds the model, output acceptance is checked
    always @(posedge clk)
    begin : monitor
        result_t r;
        result_t want;
        in_fire <= s_tvalid && s_tready;
        if (cfg_valid && cfg_ready)
            target_code = cfg_data;
        if (s_tvalid && s_tready)
        begin
            parse_byte(s_tdata, s_tuser, s_tlast, r);
            expected_words.push_back(r);
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got tuser=%h tdata=%h tlast=%b",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser[3:0]));
                check_field("payload_valid", 32'(want.payload_valid), 32'(m_tuser[4]));
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                check_field("payload_index", 32'(want.payload_index), 32'(m_tdata[23:8]));
                check_field("payload_last", 32'(want.payload_last), 32'(m_tlast));
                check_field("big_endian", 32'(want.big_endian), 32'(m_tdata[24]));
                check_field("ifd_offset", want.ifd_offset, m_tdata[56:25]);
                check_field("tdata pad", 32'h0, 32'(m_tdata[63:57]));
            end
        end
    end

    // sender: bursts with random gaps, may wait for a full drain before a file
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : driver
        file_byte_t nxt;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() != 0 &&
                     (!pending_bytes[0].drain || expected_words.size() == 0))
            begin
                nxt = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.sof;
                s_tlast  <= nxt.eof;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern steps through six modes on stall_tick, plus requested long holds
    int hold_left = 0;
    int holds_done = 0;
    int stall_tick = 0;

    always @(negedge clk)
    begin : receiver
        stall_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (holds_done != holdoff_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            case ((stall_tick / 64) % 6)
                0, 1:    m_tready <= 1'b1;
                2:       m_tready <= 1'($urandom_range(0, 1));
                3:       m_tready <= (stall_tick % 3) != 0;
                4:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic flush_file(input bit mark_last, input bit drain);
        foreach (file_bytes[i])
            pending_bytes.push_back('{data: file_bytes[i], sof: (i == 0),
                                      eof: mark_last && (i == file_bytes.size() - 1),
                                      drain: drain && (i == 0)});
        queued_total += file_bytes.size();
        file_bytes = {};
    endtask

    function automatic logic [7:0] filler_code();
        logic [7:0] code;
        do
            code = 8'($urandom);
        while (code == gen_target || code == MK_SOS || code == MK_SOI || code == MK_EOI);
        return code;
    endfunction

    task automatic add_filler_segment();
        int body;
        if ($urandom_range(0, 4) == 0 && gen_target != MK_SOI && gen_target != MK_EOI)
        begin
            file_bytes.push_back(MK_PREFIX);
            file_bytes.push_back($urandom_range(0, 1) ? MK_SOI : MK_EOI);
        end
        else
        begin
            body = $urandom_range(0, 8);
            file_bytes.push_back(MK_PREFIX);
            file_bytes.push_back(filler_code());
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'(body + 2));
            repeat (body)
                file_bytes.push_back(8'($urandom));
        end
    endtask

    function automatic flaw_t pick_flaw();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)      return FLAW_NONE;
        else if (roll < 48) return FLAW_SIG;
        else if (roll < 54) return FLAW_ORDER;
        else if (roll < 60) return FLAW_MAGIC;
        else if (roll < 68) return FLAW_SHORT;
        else if (roll < 78) return FLAW_TRUNC;
        else if (roll < 82) return FLAW_NO_FF;
        else if (roll < 86) return FLAW_SOS_FIRST;
        else if (roll < 90) return FLAW_TINY_LEN;
        else if (roll < 92) return FLAW_WRAP_SKIP;
        else if (roll < 96) return FLAW_NOISE;
        return FLAW_BAD_SOI;
    endfunction

    task automatic add_random_file(input bit force_drain);
        flaw_t       flaw;
        logic [7:0]  payload[$];
        logic [7:0]  b;
        logic [31:0] ifd;
        logic [15:0] magic_w;
        logic [15:0] seg_len;
        bit          mm;
        bit          mark_last;
        int          plen;
        int          cut;
        flaw = pick_flaw();
        mark_last = ($urandom_range(0, 3) != 0);
        file_bytes = {};
        if (flaw == FLAW_NOISE)
        begin
            if ($urandom_range(0, 1))
            begin
                file_bytes.push_back(MK_PREFIX);
                file_bytes.push_back(MK_SOI);
            end
            repeat ($urandom_range(1, 16))
                file_bytes.push_back(8'($urandom));
        end
        else if (flaw == FLAW_BAD_SOI)
        begin
            if ($urandom_range(0, 1))
            begin
                do b = 8'($urandom); while (b == MK_PREFIX);
                file_bytes.push_back(b);
            end
            else
            begin
                file_bytes.push_back(MK_PREFIX);
                do b = 8'($urandom); while (b == MK_SOI);
                file_bytes.push_back(b);
            end
            repeat ($urandom_range(0, 4))
                file_bytes.push_back(8'($urandom));
        end
        else
        begin
            file_bytes.push_back(MK_PREFIX);
            file_bytes.push_back(MK_SOI);
            repeat ($urandom_range(0, 3))
                add_filler_segment();
            case (flaw)
                FLAW_NO_FF:
                begin
                    do b = 8'($urandom); while (b == MK_PREFIX);
                    file_bytes.push_back(b);
                end
                FLAW_SOS_FIRST:
                begin
                    file_bytes.push_back(MK_PREFIX);
                    file_bytes.push_back(MK_SOS);
                end
                FLAW_TINY_LEN:
                begin
                    file_bytes.push_back(MK_PREFIX);
                    file_bytes.push_back(gen_target);
                    file_bytes.push_back(8'h00);
                    file_bytes.push_back(8'($urandom_range(0, 2)));
                end
                FLAW_WRAP_SKIP:
                begin
                    // length 0 or 1 wraps to a huge skip, the file ends inside it
                    file_bytes.push_back(MK_PREFIX);
                    file_bytes.push_back(filler_code());
                    file_bytes.push_back(8'h00);
                    file_bytes.push_back(8'($urandom_range(0, 1)));
                    repeat ($urandom_range(3, 12))
                        file_bytes.push_back(8'($urandom));
                    mark_last = 1'b1;
                end
                default:
                begin
                    mm = 1'($urandom_range(0, 1));
                    ifd = $urandom;
                    magic_w = (flaw == FLAW_MAGIC) ? TIFF_MAGIC ^ 16'($urandom_range(1, 65535))
                                                   : TIFF_MAGIC;
                    for (int i = 0; i < 6; i++)
                        payload.push_back(EXIF_SIG[i]);
                    payload.push_back(mm ? ORDER_MM : ORDER_II);
                    payload.push_back(mm ? ORDER_MM : ORDER_II);
                    if (mm)
                    begin
                        payload.push_back(magic_w[15:8]);
                        payload.push_back(magic_w[7:0]);
                        for (int i = 3; i >= 0; i--)
                            payload.push_back(ifd[8*i +: 8]);
                    end
                    else
                    begin
                        payload.push_back(magic_w[7:0]);
                        payload.push_back(magic_w[15:8]);
                        for (int i = 0; i < 4; i++)
                            payload.push_back(ifd[8*i +: 8]);
                    end
                    if (flaw == FLAW_SHORT)
                        plen = $urandom_range(1, 13);
                    else if ($urandom_range(0, 39) == 0)
                        plen = 14 + $urandom_range(250, 300);
                    else
                        plen = 14 + $urandom_range(0, 8);
                    while (payload.size() < plen)
                        payload.push_back(8'($urandom));
                    while (payload.size() > plen)
                        void'(payload.pop_back());
                    if (flaw == FLAW_SIG)
                        payload[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
                    if (flaw == FLAW_ORDER)
                        payload[$urandom_range(6, 7)] ^= 8'($urandom_range(1, 255));
                    seg_len = 16'(plen + 2);
                    file_bytes.push_back(MK_PREFIX);
                    file_bytes.push_back(gen_target);
                    file_bytes.push_back(seg_len[15:8]);
                    file_bytes.push_back(seg_len[7:0]);
                    foreach (payload[i])
                        file_bytes.push_back(payload[i]);
                end
            endcase
            if (flaw == FLAW_TRUNC)
            begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
            else if (flaw != FLAW_WRAP_SKIP)
            begin
                // bytes after the verdict are ignored until the next file
                repeat ($urandom_range(0, 3))
                    file_bytes.push_back(8'($urandom));
            end
        end
        flush_file(mark_last, force_drain || ($urandom_range(0, 11) == 0));
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    task automatic write_target(input logic [7:0] code);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_target = code;
    endtask

    initial
    begin : main
        logic [7:0] targets[8];
        int start;
        int nfiles;
        targets = '{8'hE1, 8'h00, 8'hFF, MK_SOS, MK_SOI, MK_EOI, 8'h7F, TARGET_RESET};
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short files on the reset target: each ends in a verdict before any payload
        file_bytes = '{8'h00};
        flush_file(1'b1, 1'b0);
        file_bytes = '{MK_PREFIX, 8'h00};
        flush_file(1'b1, 1'b0);
        file_bytes = '{MK_PREFIX, MK_SOI, 8'h00};
        flush_file(1'b0, 1'b0);
        file_bytes = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOS};
        flush_file(1'b0, 1'b0);
        file_bytes = '{MK_PREFIX, MK_SOI, MK_PREFIX, TARGET_RESET, 8'h00, 8'h01};
        flush_file(1'b0, 1'b0);
        file_bytes = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI,
                       MK_PREFIX, TARGET_RESET, 8'h00, 8'h02};
        flush_file(1'b1, 1'b0);
        settle();

        foreach (targets[t])
        begin
            write_target(targets[t]);
            start = queued_total;
            nfiles = 0;
            while (queued_total - start < PHASE_BYTES)
            begin
                add_random_file(nfiles == 3);
                nfiles++;
            end
            // long receiver hold while the sender keeps offering
            holdoff_requests++;
            settle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
